### sv/prp_pkg.sv
// ----------------------------------------------------------------------------
// prp_pkg
// Shared types and codes of the PageRank power iteration block.
// ----------------------------------------------------------------------------
package prp_pkg;

    localparam int NODE_W = 10;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [1:0] CFG_DAMPING    = 2'd1;
    localparam logic [1:0] CFG_TOLERANCE  = 2'd2;
    localparam logic [1:0] CFG_ITER_LIMIT = 2'd3;

    typedef struct packed {
        logic [1:0]        command;
        logic [NODE_W-1:0] source_node;
        logic [NODE_W-1:0] dest_node;
    } prp_req_t;

    typedef struct packed {
        logic [31:0] rank_value;
        logic [15:0] iterations_done;
        logic        converged;
        logic [1:0]  status;
    } prp_rsp_t;

    typedef enum logic [1:0] {
        DIV_INIT,
        DIV_OFFSET,
        DIV_EDGE
    } prp_div_sel_t;

    typedef struct packed {
        logic         cap;
        logic         idx_clr;
        logic         idx_inc;
        logic         clr_wr;
        logic         ec_clr;
        logic         load_rd;
        logic         load_wr;
        logic         rank_rd;
        logic         run_start;
        logic         div_start;
        prp_div_sel_t div_sel;
        logic         fill_wr;
        logic         iter_start;
        logic         edge_rd;
        logic         edge_op;
        logic         acc_rd;
        logic         acc_wr;
        logic         node_rd;
        logic         node_mul;
        logic         node_wr;
        logic         iter_end;
        logic         res_set;
    } prp_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       in_bad;
        logic       idx_last_n;
        logic       idx_last_max;
        logic       idx_last_edge;
        logic       edge_none;
        logic       edge_skip;
        logic       deg_zero;
        logic       div_done;
        logic       conv_hit;
        logic       lim_hit;
    } prp_sts_t;

endpackage

### sv/pagerank_power_iteration.sv
// ----------------------------------------------------------------------------
// pagerank_power_iteration: one item at a time. Every item gives one result, and
// the next item is taken as that result is issued.
// Run: the serial divider forms the initial rank and the offset, all ranks are filled,
// then each iteration divides over every edge not skipped and updates every node.
// After reset the out-degree memory is cleared entry by entry; no item is taken meanwhile.
// ----------------------------------------------------------------------------
module pagerank_power_iteration #(
    parameter int MAX_NODES      = 1024,
    parameter int MAX_EDGES      = 8192,
    parameter int RANK_FRAC_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              req_valid,
    output logic              req_stall,
    input  prp_pkg::prp_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output prp_pkg::prp_rsp_t rsp
);

    prp_pkg::prp_cmd_t cmd;
    prp_pkg::prp_sts_t sts;

    prp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    prp_dpath #(
        .MAX_NODES      (MAX_NODES),
        .MAX_EDGES      (MAX_EDGES),
        .RANK_FRAC_BITS (RANK_FRAC_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (rsp)
    );

endmodule

### sv/prp_div.sv
// ----------------------------------------------------------------------------
// prp_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prp_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 14
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [CW-1:0]    cnt_reg;
    logic             done_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, q_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(NUM_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= num;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            if (fits)
            begin
                rem_reg <= DEN_W'(trial - {1'b0, den_reg});
                q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DEN_W-1:0];
                q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

### sv/prp_dpath.sv
// ----------------------------------------------------------------------------
// prp_dpath
// Datapath: configuration, edge/degree/rank memories, divider, accumulation.
// ----------------------------------------------------------------------------
module prp_dpath #(
    parameter int MAX_NODES      = 1024,
    parameter int MAX_EDGES      = 8192,
    parameter int RANK_FRAC_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  prp_pkg::prp_req_t req,
    input  prp_pkg::prp_cmd_t cmd,
    output prp_pkg::prp_sts_t sts,
    output prp_pkg::prp_rsp_t rsp
);

    localparam int AW   = $clog2(MAX_NODES);
    localparam int NW   = $clog2(MAX_NODES + 1);
    localparam int EW   = $clog2(MAX_EDGES);
    localparam int ECW  = $clog2(MAX_EDGES + 1);
    localparam int IW   = (AW > EW) ? AW : EW;
    localparam int RW   = RANK_FRAC_BITS;
    localparam int QW   = RW + 1;
    localparam int DVW  = (ECW > NW) ? ECW : NW;
    localparam int M1   = (IW > ECW) ? IW : ECW;
    localparam int CTW  = ((M1 > NW) ? M1 : NW) + 1;
    localparam int XW   = RW + 32;
    localparam int TSHL = (RW >= 32) ? RW - 32 : 0;
    localparam int TSHR = (RW >= 32) ? 0 : 32 - RW;
    localparam int NDW  = prp_pkg::NODE_W;

    // configuration
    logic [10:0] nc_reg;
    logic [15:0] damp_reg;
    logic [31:0] tol_reg;
    logic [15:0] lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg   <= 11'd1;
            damp_reg <= 16'd55705;
            tol_reg  <= 32'd42950;
            lim_reg  <= 16'd1000;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                prp_pkg::CFG_NODE_COUNT: nc_reg   <= cfg_data[10:0];
                prp_pkg::CFG_DAMPING:    damp_reg <= cfg_data[15:0];
                prp_pkg::CFG_TOLERANCE:  tol_reg  <= cfg_data;
                prp_pkg::CFG_ITER_LIMIT: lim_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [NW-1:0] n_eff;
    logic [15:0]   lim_eff;
    logic [63:0]   tol64;

    always_comb
    begin
        if (nc_reg == '0)
            n_eff = NW'(1);
        else if (32'(nc_reg) > MAX_NODES)
            n_eff = NW'(MAX_NODES);
        else
            n_eff = NW'(nc_reg);
    end

    assign lim_eff = (lim_reg == '0) ? 16'd1 : lim_reg;
    assign tol64   = (64'(tol_reg) << TSHL) >> TSHR;

    // captured item
    logic [1:0]     q_cmd;
    logic [NDW-1:0] q_src;
    logic [NDW-1:0] q_dst;
    logic [1:0]     q_st;
    logic [1:0]     st_new;
    logic           src_ok;
    logic           dst_ok;
    logic [ECW-1:0] ec_reg;
    logic           full;

    assign src_ok = 32'(req.source_node) < 32'(n_eff);
    assign dst_ok = 32'(req.dest_node) < 32'(n_eff);
    assign full   = ec_reg == ECW'(MAX_EDGES);

    always_comb
    begin
        st_new = prp_pkg::ST_OK;
        if (req.command == prp_pkg::CMD_LOAD)
        begin
            if (!src_ok || !dst_ok)
                st_new = prp_pkg::ST_RANGE;
            else if (full)
                st_new = prp_pkg::ST_FULL;
        end
        else if (req.command == prp_pkg::CMD_READ)
        begin
            if (!src_ok)
                st_new = prp_pkg::ST_RANGE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            q_cmd <= req.command;
            q_src <= req.source_node;
            q_dst <= req.dest_node;
            q_st  <= st_new;
        end
    end

    // index counter and edge count
    logic [IW-1:0] idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            ec_reg  <= '0;
        end
        else
        begin
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + IW'(1);
            if (cmd.ec_clr)
                ec_reg <= '0;
            else if (cmd.load_wr)
                ec_reg <= ec_reg + ECW'(1);
        end
    end

    logic [AW-1:0] idx_a;
    logic [AW-1:0] src_a;
    assign idx_a = idx_reg[AW-1:0];
    assign src_a = AW'(q_src);

    // edge store
    logic [2*NDW-1:0] edge_mem [MAX_EDGES];
    logic [NDW-1:0]   e_src;
    logic [NDW-1:0]   e_dst;
    logic [AW-1:0]    s_a;
    logic [AW-1:0]    t_a;

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
            edge_mem[ec_reg[EW-1:0]] <= {q_src, q_dst};
        if (cmd.edge_rd)
            {e_src, e_dst} <= edge_mem[idx_reg[EW-1:0]];
    end

    assign s_a = AW'(e_src);
    assign t_a = AW'(e_dst);

    // out-degree store
    logic [ECW-1:0] deg_mem [MAX_NODES];
    logic [ECW-1:0] deg_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
            deg_mem[idx_a] <= '0;
        else if (cmd.load_wr)
            deg_mem[src_a] <= deg_rd_reg + ECW'(1);
        if (cmd.load_rd)
            deg_rd_reg <= deg_mem[src_a];
        else if (cmd.edge_op)
            deg_rd_reg <= deg_mem[s_a];
    end

    // divider
    logic [QW-1:0]    div_num;
    logic [DVW-1:0]   div_den;
    logic [QW-1:0]    div_quo;
    logic             div_done;
    logic [16:0]      omd;
    prp_pkg::prp_div_sel_t sel_reg;
    logic [RW-1:0]    prev_rd_reg;

    assign omd = 17'h10000 - {1'b0, damp_reg};

    always_comb
    begin
        unique case (cmd.div_sel)
            prp_pkg::DIV_INIT:
            begin
                div_num = QW'(1) << RW;
                div_den = DVW'(n_eff);
            end
            prp_pkg::DIV_OFFSET:
            begin
                div_num = QW'(omd) << (RW - 16);
                div_den = DVW'(n_eff);
            end
            default:
            begin
                div_num = QW'(prev_rd_reg);
                div_den = DVW'(deg_rd_reg);
            end
        endcase
    end

    prp_div #(
        .NUM_W (QW),
        .DEN_W (DVW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    logic [RW-1:0] init_reg;
    logic [QW-1:0] offset_reg;
    logic [RW-1:0] term_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
            sel_reg <= cmd.div_sel;
        if (div_done)
        begin
            unique case (sel_reg)
                prp_pkg::DIV_INIT:   init_reg   <= div_quo[RW] ? '1 : div_quo[RW-1:0];
                prp_pkg::DIV_OFFSET: offset_reg <= div_quo;
                default:             term_reg   <= div_quo[RW-1:0];
            endcase
        end
    end

    // rank, previous rank and accumulator stores
    logic [RW-1:0]    rank_mem [MAX_NODES];
    logic [RW-1:0]    prev_mem [MAX_NODES];
    logic [RW-1:0]    acc_mem  [MAX_NODES];
    logic [RW-1:0]    rank_rd_reg;
    logic [RW-1:0]    acc_rd_reg;
    logic [RW+15:0]   prod_reg;
    logic [RW+1:0]    r_sum;
    logic [RW-1:0]    r_new;
    logic [RW:0]      a_sum;
    logic [RW-1:0]    a_new;
    logic [RW-1:0]    dlt;
    logic [64:0]      d_sum;

    assign r_sum = (RW+2)'(offset_reg) + (RW+2)'(prod_reg[RW+15:16]);
    assign r_new = (r_sum[RW+1:RW] != 2'b00) ? '1 : r_sum[RW-1:0];
    assign a_sum = (RW+1)'(acc_rd_reg) + (RW+1)'(term_reg);
    assign a_new = a_sum[RW] ? '1 : a_sum[RW-1:0];
    assign dlt   = (r_new >= prev_rd_reg) ? r_new - prev_rd_reg : prev_rd_reg - r_new;

    always_ff @(posedge clk)
    begin
        if (cmd.fill_wr)
            rank_mem[idx_a] <= init_reg;
        else if (cmd.node_wr)
            rank_mem[idx_a] <= r_new;
        if (cmd.rank_rd)
            rank_rd_reg <= rank_mem[src_a];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill_wr)
            prev_mem[idx_a] <= init_reg;
        else if (cmd.node_wr)
            prev_mem[idx_a] <= r_new;
        if (cmd.edge_op)
            prev_rd_reg <= prev_mem[s_a];
        else if (cmd.node_rd)
            prev_rd_reg <= prev_mem[idx_a];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill_wr || cmd.node_wr)
            acc_mem[idx_a] <= '0;
        else if (cmd.acc_wr)
            acc_mem[t_a] <= a_new;
        if (cmd.acc_rd)
            acc_rd_reg <= acc_mem[t_a];
        else if (cmd.node_rd)
            acc_rd_reg <= acc_mem[idx_a];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.node_mul)
            prod_reg <= (RW+16)'(acc_rd_reg) * (RW+16)'(damp_reg);
    end

    // convergence tracking
    logic [63:0] diff_reg;
    logic [15:0] iter_reg;
    logic        conv_reg;
    logic        conv_hit;
    logic        lim_hit;

    assign d_sum    = 65'(diff_reg) + 65'(dlt);
    assign conv_hit = diff_reg <= tol64;
    assign lim_hit  = (17'(iter_reg) + 17'd1) >= 17'(lim_eff);

    always_ff @(posedge clk)
    begin
        if (cmd.iter_start)
            diff_reg <= '0;
        else if (cmd.node_wr)
            diff_reg <= d_sum[64] ? '1 : d_sum[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
            conv_reg <= 1'b0;
        end
        else if (cmd.run_start)
        begin
            iter_reg <= '0;
            conv_reg <= 1'b0;
        end
        else if (cmd.iter_end)
        begin
            iter_reg <= iter_reg + 16'd1;
            conv_reg <= conv_hit;
        end
    end

    // result
    logic [XW-1:0] rank_x;
    logic [31:0]   rank_sat;

    assign rank_x   = XW'(rank_rd_reg);
    assign rank_sat = (rank_x > XW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : rank_x[31:0];

    always_ff @(posedge clk)
    begin
        if (cmd.res_set)
        begin
            rsp.rank_value      <= (q_cmd == prp_pkg::CMD_READ && q_st == prp_pkg::ST_OK)
                                   ? rank_sat : 32'd0;
            rsp.iterations_done <= iter_reg;
            rsp.converged       <= conv_reg;
            rsp.status          <= q_st;
        end
    end

    // status to controller
    always_comb
    begin
        sts.cmd           = q_cmd;
        sts.in_bad        = q_st != prp_pkg::ST_OK;
        sts.idx_last_n    = (CTW'(idx_reg) + CTW'(1)) == CTW'(n_eff);
        sts.idx_last_max  = idx_reg == IW'(MAX_NODES - 1);
        sts.idx_last_edge = (CTW'(idx_reg) + CTW'(1)) == CTW'(ec_reg);
        sts.edge_none     = ec_reg == '0;
        sts.edge_skip     = (32'(e_src) >= 32'(n_eff)) || (32'(e_dst) >= 32'(n_eff));
        sts.deg_zero      = deg_rd_reg == '0;
        sts.div_done      = div_done;
        sts.conv_hit      = conv_hit;
        sts.lim_hit       = lim_hit;
    end

endmodule

### sv/prp_ctrl.sv
// ----------------------------------------------------------------------------
// prp_ctrl
// Controller: sequences load, read, clear and the power iteration runs.
// ----------------------------------------------------------------------------
module prp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    input  prp_pkg::prp_sts_t sts,
    output prp_pkg::prp_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_DISPATCH,
        S_LOAD_WR,
        S_RUN_W0,
        S_RUN_D1,
        S_RUN_W1,
        S_FILL,
        S_IT_START,
        S_EDGE_RD,
        S_EDGE_OP,
        S_EDGE_DIV,
        S_EDGE_W,
        S_ACC_RD,
        S_ACC_WR,
        S_EDGE_NEXT,
        S_NODE_RD,
        S_NODE_MUL,
        S_NODE_WR,
        S_IT_END,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   clr_rsp_reg;
    logic   clr_rsp_next;
    logic   accept;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        clr_rsp_next = clr_rsp_reg;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.idx_last_max)
                begin
                    cmd.idx_clr  = 1'b1;
                    clr_rsp_next = 1'b0;
                    state_next   = clr_rsp_reg ? S_FIN : S_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_IDLE:
            begin
                cmd.cap = accept;
                if (accept)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                unique case (sts.cmd)
                    prp_pkg::CMD_LOAD:
                    begin
                        if (sts.in_bad)
                            state_next = S_FIN;
                        else
                        begin
                            cmd.load_rd = 1'b1;
                            state_next  = S_LOAD_WR;
                        end
                    end
                    prp_pkg::CMD_RUN:
                    begin
                        cmd.run_start = 1'b1;
                        cmd.idx_clr   = 1'b1;
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = prp_pkg::DIV_INIT;
                        state_next    = S_RUN_W0;
                    end
                    prp_pkg::CMD_READ:
                    begin
                        cmd.rank_rd = 1'b1;
                        state_next  = S_FIN;
                    end
                    default:
                    begin
                        cmd.ec_clr   = 1'b1;
                        cmd.idx_clr  = 1'b1;
                        clr_rsp_next = 1'b1;
                        state_next   = S_CLR;
                    end
                endcase
            end
            S_LOAD_WR:
            begin
                cmd.load_wr = 1'b1;
                state_next  = S_FIN;
            end
            S_RUN_W0:
            begin
                if (sts.div_done)
                    state_next = S_RUN_D1;
            end
            S_RUN_D1:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = prp_pkg::DIV_OFFSET;
                state_next    = S_RUN_W1;
            end
            S_RUN_W1:
            begin
                if (sts.div_done)
                    state_next = S_FILL;
            end
            S_FILL:
            begin
                cmd.fill_wr = 1'b1;
                if (sts.idx_last_n)
                    state_next = S_IT_START;
                else
                    cmd.idx_inc = 1'b1;
            end
            S_IT_START:
            begin
                cmd.iter_start = 1'b1;
                cmd.idx_clr    = 1'b1;
                state_next     = sts.edge_none ? S_NODE_RD : S_EDGE_RD;
            end
            S_EDGE_RD:
            begin
                cmd.edge_rd = 1'b1;
                state_next  = S_EDGE_OP;
            end
            S_EDGE_OP:
            begin
                if (sts.edge_skip)
                    state_next = S_EDGE_NEXT;
                else
                begin
                    cmd.edge_op = 1'b1;
                    state_next  = S_EDGE_DIV;
                end
            end
            S_EDGE_DIV:
            begin
                if (sts.deg_zero)
                    state_next = S_EDGE_NEXT;
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = prp_pkg::DIV_EDGE;
                    state_next    = S_EDGE_W;
                end
            end
            S_EDGE_W:
            begin
                cmd.div_sel = prp_pkg::DIV_EDGE;
                if (sts.div_done)
                    state_next = S_ACC_RD;
            end
            S_ACC_RD:
            begin
                cmd.acc_rd = 1'b1;
                state_next = S_ACC_WR;
            end
            S_ACC_WR:
            begin
                cmd.acc_wr = 1'b1;
                state_next = S_EDGE_NEXT;
            end
            S_EDGE_NEXT:
            begin
                if (sts.idx_last_edge)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_NODE_RD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_EDGE_RD;
                end
            end
            S_NODE_RD:
            begin
                cmd.node_rd = 1'b1;
                state_next  = S_NODE_MUL;
            end
            S_NODE_MUL:
            begin
                cmd.node_mul = 1'b1;
                state_next   = S_NODE_WR;
            end
            S_NODE_WR:
            begin
                cmd.node_wr = 1'b1;
                if (sts.idx_last_n)
                    state_next = S_IT_END;
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_NODE_RD;
                end
            end
            S_IT_END:
            begin
                cmd.iter_end = 1'b1;
                state_next   = (sts.conv_hit || sts.lim_hit) ? S_FIN : S_IT_START;
            end
            S_FIN:
            begin
                // hold while the previous result still waits
                if (!(rsp_valid_reg && rsp_stall))
                begin
                    cmd.res_set = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            rsp_valid_reg <= 1'b0;
            clr_rsp_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_rsp_reg <= clr_rsp_next;
            if (cmd.res_set)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

endmodule

### tb/pagerank_power_iteration_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pagerank_power_iteration_tb
// Self-checking bench for the PageRank block: a scoreboard object mirrors the
// edge store, degrees and fixed-point iteration, and every response is checked
// field by field. Directed corner items come first, then random traffic in three
// flow-control phases.
// ----------------------------------------------------------------------------
module pagerank_power_iteration_tb;

    localparam int MAX_N      = 1024;
    localparam int MAX_E      = 8192;
    localparam int IDLE_LIMIT = 400000;
    localparam longint unsigned RMAX = 64'hFFFF_FFFF;

    class pagerank_scoreboard;
        int unsigned       node_cfg, damp, tol, iter_lim;
        bit [9:0]          edge_src[MAX_E];
        bit [9:0]          edge_dst[MAX_E];
        int unsigned       edge_total;
        int unsigned       degree[MAX_N];
        longint unsigned   rank[MAX_N];
        bit                ranked[MAX_N];
        int unsigned       last_iters;
        bit                last_conv;
        prp_pkg::prp_rsp_t pending[$];
        int                errors;

        function new();
            node_cfg = 1; damp = 55705; tol = 42950; iter_lim = 1000;
            edge_total = 0; last_iters = 0; last_conv = 0; errors = 0;
            foreach (degree[i])
            begin
                degree[i] = 0;
                rank[i] = 0;
                ranked[i] = 0;
            end
        endfunction

        function int unsigned nodes();
            if (node_cfg == 0) return 1;
            if (node_cfg > MAX_N) return MAX_N;
            return node_cfg;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                prp_pkg::CFG_NODE_COUNT: node_cfg = v[10:0];
                prp_pkg::CFG_DAMPING:    damp = v[15:0];
                prp_pkg::CFG_TOLERANCE:  tol = v;
                prp_pkg::CFG_ITER_LIMIT: iter_lim = v[15:0];
                default: ;
            endcase
        endfunction

        function void iterate();
            longint unsigned prev[MAX_N];
            longint unsigned acc[MAX_N];
            longint unsigned init_rank, offset, diff, r, dlt, term;
            int unsigned n, limit, iters, s, t;
            bit done;
            n = nodes();
            limit = (iter_lim == 0) ? 1 : iter_lim;
            init_rank = (64'd1 << 32) / n;
            if (init_rank > RMAX) init_rank = RMAX;
            offset = (longint'(65536 - damp) << 16) / n;
            for (int v = 0; v < n; v++)
            begin
                rank[v] = init_rank;
                ranked[v] = 1;
            end
            last_conv = 0;
            iters = 0;
            done = 0;
            while (!done)
            begin
                diff = 0;
                for (int v = 0; v < n; v++)
                begin
                    prev[v] = rank[v];
                    acc[v] = 0;
                end
                for (int e = 0; e < edge_total; e++)
                begin
                    s = edge_src[e];
                    t = edge_dst[e];
                    if (s >= n || t >= n || degree[s] == 0) continue;
                    term = prev[s] / degree[s];
                    acc[t] += term;
                    if (acc[t] > RMAX) acc[t] = RMAX;
                end
                for (int v = 0; v < n; v++)
                begin
                    r = offset + ((acc[v] * damp) >> 16);
                    if (r > RMAX) r = RMAX;
                    rank[v] = r;
                    dlt = (r >= prev[v]) ? r - prev[v] : prev[v] - r;
                    diff = (diff + dlt < diff) ? 64'hFFFF_FFFF_FFFF_FFFF : diff + dlt;
                end
                iters++;
                if (diff <= longint'(tol))
                begin
                    last_conv = 1;
                    done = 1;
                end
                else if (iters >= limit)
                    done = 1;
            end
            last_iters = iters & 16'hFFFF;
        endfunction

        function void note(prp_pkg::prp_req_t q);
            prp_pkg::prp_rsp_t x;
            int unsigned n;
            n = nodes();
            x.rank_value = '0;
            x.status = prp_pkg::ST_OK;
            case (q.command)
                prp_pkg::CMD_LOAD:
                begin
                    if (q.source_node >= n || q.dest_node >= n)
                        x.status = prp_pkg::ST_RANGE;
                    else if (edge_total >= MAX_E)
                        x.status = prp_pkg::ST_FULL;
                    else
                    begin
                        edge_src[edge_total] = q.source_node;
                        edge_dst[edge_total] = q.dest_node;
                        edge_total++;
                        degree[q.source_node]++;
                    end
                end
                prp_pkg::CMD_RUN: iterate();
                prp_pkg::CMD_READ:
                begin
                    if (q.source_node >= n)
                        x.status = prp_pkg::ST_RANGE;
                    else
                        x.rank_value = rank[q.source_node][31:0];
                end
                default:
                begin
                    edge_total = 0;
                    foreach (degree[i]) degree[i] = 0;
                end
            endcase
            x.iterations_done = last_iters[15:0];
            x.converged = last_conv;
            pending.push_back(x);
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) $display("mismatch: %s", msg);
        endfunction

        function void check(prp_pkg::prp_rsp_t got);
            prp_pkg::prp_rsp_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected item %h", got));
                return;
            end
            want = pending.pop_front();
            if (got.rank_value !== want.rank_value)
                report($sformatf("rank_value exp %h got %h", want.rank_value, got.rank_value));
            if (got.iterations_done !== want.iterations_done)
                report($sformatf("iterations_done exp %0d got %0d",
                                 want.iterations_done, got.iterations_done));
            if (got.converged !== want.converged)
                report($sformatf("converged exp %b got %b", want.converged, got.converged));
            if (got.status !== want.status)
                report($sformatf("status exp %0d got %0d", want.status, got.status));
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_write;
    logic [1:0]        cfg_index;
    logic [31:0]       cfg_data;
    logic              req_valid;
    logic              req_stall;
    prp_pkg::prp_req_t req;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    prp_pkg::prp_rsp_t rsp;

    pagerank_scoreboard sb;
    int send_idle;
    int recv_idle;
    int quiet_cycles = 0;

    pagerank_power_iteration uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        rsp_stall <= ($urandom_range(99) < recv_idle);

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check(rsp);
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send(logic [1:0] cmd, int unsigned src, int unsigned dst);
        prp_pkg::prp_req_t q;
        q.command = cmd;
        q.source_node = src[9:0];
        q.dest_node = dst[9:0];
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= q;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sb.note(q);
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic configure(int unsigned n, int unsigned d, int unsigned t, int unsigned l);
        drain();
        write_reg(prp_pkg::CFG_NODE_COUNT, n);
        write_reg(prp_pkg::CFG_DAMPING, d);
        write_reg(prp_pkg::CFG_TOLERANCE, t);
        write_reg(prp_pkg::CFG_ITER_LIMIT, l);
    endtask

    task automatic random_items(int count);
        int unsigned n, pick, src, dst;
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 == 0)
            begin
                pick = $urandom_range(9);
                n = (pick == 0) ? 0 : (pick == 1) ? 2047 : (pick == 2) ? 1024
                    : $urandom_range(1, 16);
                configure(n, (pick == 3) ? 0 : $urandom_range(65535),
                          (pick < 5) ? $urandom : $urandom_range(1 << 20),
                          $urandom_range(0, 6));
            end
            n = sb.nodes();
            pick = $urandom_range(99);
            src = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(n - 1);
            dst = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(n - 1);
            if (pick < 4)
            begin
                if (sb.edge_total > 64)
                    send(prp_pkg::CMD_CLEAR, src, dst);
                else
                    send(prp_pkg::CMD_RUN, src, dst);
            end
            else if (pick < 22 && !(src < n && !sb.ranked[src]))
                send(prp_pkg::CMD_READ, src, dst);
            else if (pick < 22 || pick >= 30)
                send(prp_pkg::CMD_LOAD, src, dst);
            else
                send(prp_pkg::CMD_CLEAR, src, dst);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = prp_pkg::CFG_NODE_COUNT;
        cfg_data = '0;
        req_valid = 1'b0;
        req = '0;
        send_idle = 0;
        recv_idle = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        configure(4, 55705, 42950, 5);
        send(prp_pkg::CMD_LOAD, 0, 1);
        send(prp_pkg::CMD_LOAD, 1, 2);
        send(prp_pkg::CMD_LOAD, 2, 0);
        send(prp_pkg::CMD_LOAD, 0, 2);
        send(prp_pkg::CMD_LOAD, 5, 0);
        send(prp_pkg::CMD_LOAD, 0, 1023);
        send(prp_pkg::CMD_RUN, 0, 0);
        send(prp_pkg::CMD_READ, 0, 0);
        send(prp_pkg::CMD_READ, 3, 0);
        send(prp_pkg::CMD_READ, 1023, 0);
        send(prp_pkg::CMD_CLEAR, 0, 0);
        send(prp_pkg::CMD_LOAD, 3, 3);
        send(prp_pkg::CMD_RUN, 0, 0);
        send(prp_pkg::CMD_READ, 3, 0);
        configure(0, 55705, 42950, 5);
        send(prp_pkg::CMD_LOAD, 0, 0);
        send(prp_pkg::CMD_RUN, 0, 0);
        send(prp_pkg::CMD_READ, 0, 0);
        configure(2047, 65535, 0, 2);
        send(prp_pkg::CMD_LOAD, 1023, 0);
        send(prp_pkg::CMD_LOAD, 0, 1023);
        send(prp_pkg::CMD_RUN, 0, 0);
        send(prp_pkg::CMD_READ, 1023, 0);
        configure(2, 65535, 0, 2);
        send(prp_pkg::CMD_RUN, 0, 0);
        send(prp_pkg::CMD_READ, 1, 0);
        configure(2, 0, 32'hFFFF_FFFF, 65535);
        send(prp_pkg::CMD_RUN, 0, 0);
        configure(2, 0, 32'hFFFF_FFFF, 0);
        send(prp_pkg::CMD_RUN, 0, 0);
        send(prp_pkg::CMD_READ, 0, 0);

        configure(1, 55705, 42950, 3);
        send(prp_pkg::CMD_CLEAR, 0, 0);

        send_idle = 20;
        recv_idle = 83;
        random_items(650);
        drain();
        send_idle = 83;
        recv_idle = 20;
        random_items(650);
        drain();
        send_idle = 0;
        recv_idle = 0;
        random_items(650);
        drain();
        repeat (50) @(posedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

### sim.f
sv/prp_pkg.sv
sv/prp_div.sv
sv/prp_dpath.sv
sv/prp_ctrl.sv
sv/pagerank_power_iteration.sv
tb/pagerank_power_iteration_tb.sv
